>>> rtl/ipv6ecp_pkg.sv
// ----------------------------------------------------------------------------
// ipv6ecp_pkg
// Types and constants shared by the IPv6 extension header chain parser.
// ----------------------------------------------------------------------------
package ipv6ecp_pkg;

   localparam int OFFSET_BITS = 17;
   localparam int COUNT_BITS  = 17;
   localparam int LIMIT_BITS  = 6;
   localparam int LEFT_BITS   = 11;

   localparam logic [LIMIT_BITS-1:0] MAX_EXT_RESET = 6'd16;

   // Next-header codes that continue the chain.
   localparam logic [7:0] NH_HOP      = 8'd0;
   localparam logic [7:0] NH_ROUTING  = 8'd43;
   localparam logic [7:0] NH_FRAGMENT = 8'd44;
   localparam logic [7:0] NH_AH       = 8'd51;
   localparam logic [7:0] NH_DEST     = 8'd60;

   localparam logic [3:0] IP_VERSION  = 4'd6;

   // Byte positions inside the base header.
   localparam int POS_VERSION   = 0;
   localparam int POS_LENGTH_HI = 4;
   localparam int POS_LENGTH_LO = 5;
   localparam int POS_NEXT_HDR  = 6;
   localparam int POS_HOP_LIMIT = 7;
   localparam int POS_BASE_END  = 39;

   localparam logic [LEFT_BITS-1:0] FRAG_BODY_BYTES = 11'd7;

   typedef enum logic [2:0] {
      PH_BASE        = 3'd0,
      PH_EXT_NEXT    = 3'd1,
      PH_EXT_LEN     = 3'd2,
      PH_EXT_BODY    = 3'd3,
      PH_PAY_LIMITED = 3'd4,
      PH_PAY_ALL     = 3'd5,
      PH_ERROR       = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_GENERIC = 2'd0,
      KIND_AH      = 2'd1,
      KIND_FRAG    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CLASS_BASE    = 3'd0,
      CLASS_EXT     = 3'd1,
      CLASS_PAYLOAD = 3'd2,
      CLASS_TRIMMED = 3'd3,
      CLASS_DISCARD = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_VERSION = 2'd1,
      ST_CHAIN_LONG  = 2'd2,
      ST_TRUNCATED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       is_last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]             data_out;
      logic [2:0]             byte_class;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic                   packet_done;
      logic [1:0]             status;
      logic [7:0]             upper_protocol;
      logic [7:0]             hop_limit_out;
      logic [LIMIT_BITS-1:0]  extension_count;
      logic [COUNT_BITS-1:0]  payload_count;
      logic [COUNT_BITS-1:0]  trimmed_count;
   } rsp_type;

endpackage

>>> rtl/ipv6ecp_core.sv
// ----------------------------------------------------------------------------
// ipv6ecp_core
// Per-packet parse state and the combinational update that classes one byte.
// ----------------------------------------------------------------------------
module ipv6ecp_core
   import ipv6ecp_pkg::*;
#(
   parameter int POSITION_BITS = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  req_type               step_item,
   input  logic [LIMIT_BITS-1:0] max_ext,
   output rsp_type               step_result
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   phase_type                phase_ff,        phase_in;
   logic [POSITION_BITS-1:0] position_ff,     position_in;
   logic [15:0]              decl_len_ff,     decl_len_in;
   logic [7:0]               cur_nh_ff,       cur_nh_in;
   logic [7:0]               pend_nh_ff,      pend_nh_in;
   logic [7:0]               hop_limit_ff,    hop_limit_in;
   kind_type                 kind_ff,         kind_in;
   logic [LEFT_BITS-1:0]     left_ff,         left_in;
   logic [LIMIT_BITS-1:0]    ext_seen_ff,     ext_seen_in;
   logic [COUNT_BITS-1:0]    ext_total_ff,    ext_total_in;
   logic [COUNT_BITS-1:0]    pay_seen_ff,     pay_seen_in;
   logic [COUNT_BITS-1:0]    trim_seen_ff,    trim_seen_in;
   status_type               err_ff,          err_in;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v != CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   logic [7:0]            b;
   logic                  do_begin;
   logic                  nh_generic;
   logic                  nh_ext;
   logic [COUNT_BITS-1:0] pay_room;
   class_type             cls;
   status_type            st;

   always_comb begin
      b            = step_item.packet_byte;
      phase_in     = phase_ff;
      decl_len_in  = decl_len_ff;
      cur_nh_in    = cur_nh_ff;
      pend_nh_in   = pend_nh_ff;
      hop_limit_in = hop_limit_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      ext_seen_in  = ext_seen_ff;
      ext_total_in = ext_total_ff;
      pay_seen_in  = pay_seen_ff;
      trim_seen_in = trim_seen_ff;
      err_in       = err_ff;
      do_begin     = 1'b0;
      cls          = CLASS_DISCARD;
      pay_room     = {1'b0, decl_len_ff} - ext_total_ff;

      case (phase_ff)
         PH_BASE: begin
            cls = CLASS_BASE;
            if (position_ff == POSITION_BITS'(POS_VERSION)) begin
               if (b[7:4] != IP_VERSION) begin
                  err_in   = ST_BAD_VERSION;
                  phase_in = PH_ERROR;
               end
            end else if (position_ff == POSITION_BITS'(POS_LENGTH_HI)) begin
               decl_len_in = {b, 8'd0};
            end else if (position_ff == POSITION_BITS'(POS_LENGTH_LO)) begin
               decl_len_in = {decl_len_ff[15:8], b};
            end else if (position_ff == POSITION_BITS'(POS_NEXT_HDR)) begin
               cur_nh_in = b;
            end else if (position_ff == POSITION_BITS'(POS_HOP_LIMIT)) begin
               hop_limit_in = b;
            end
            if (position_ff >= POSITION_BITS'(POS_BASE_END) &&
                position_ff != POSITION_BITS'(POS_VERSION)) begin
               do_begin = 1'b1;
            end
         end
         PH_EXT_NEXT: begin
            cls          = CLASS_EXT;
            ext_total_in = sat_inc(ext_total_ff);
            pend_nh_in   = b;
            if (kind_ff == KIND_FRAG) begin
               left_in  = FRAG_BODY_BYTES;
               phase_in = PH_EXT_BODY;
            end else begin
               phase_in = PH_EXT_LEN;
            end
         end
         PH_EXT_LEN: begin
            cls          = CLASS_EXT;
            ext_total_in = sat_inc(ext_total_ff);
            // AH is (len + 2) * 4 bytes, the others (len + 1) * 8; two already read.
            if (kind_ff == KIND_AH) begin
               left_in = {1'b0, b, 2'b00} + LEFT_BITS'(6);
            end else begin
               left_in = {b, 3'b110};
            end
            phase_in = PH_EXT_BODY;
         end
         PH_EXT_BODY: begin
            cls          = CLASS_EXT;
            ext_total_in = sat_inc(ext_total_ff);
            if (left_ff != '0) begin
               left_in = left_ff - 1'b1;
            end
            if (left_in == '0) begin
               cur_nh_in = pend_nh_ff;
               do_begin  = 1'b1;
            end
         end
         PH_PAY_LIMITED: begin
            if (pay_seen_ff < pay_room) begin
               cls         = CLASS_PAYLOAD;
               pay_seen_in = sat_inc(pay_seen_ff);
            end else begin
               cls          = CLASS_TRIMMED;
               trim_seen_in = sat_inc(trim_seen_ff);
            end
         end
         PH_PAY_ALL: begin
            cls         = CLASS_PAYLOAD;
            pay_seen_in = sat_inc(pay_seen_ff);
         end
         default: begin
            cls = CLASS_DISCARD;
         end
      endcase

      // A header just ended: open the next extension header, the payload or the chain error.
      nh_generic = (cur_nh_in == NH_HOP) || (cur_nh_in == NH_ROUTING) ||
                   (cur_nh_in == NH_DEST);
      nh_ext     = nh_generic || (cur_nh_in == NH_AH) || (cur_nh_in == NH_FRAGMENT);
      if (do_begin) begin
         if (nh_ext) begin
            if (ext_seen_ff >= max_ext) begin
               err_in   = ST_CHAIN_LONG;
               phase_in = PH_ERROR;
            end else begin
               ext_seen_in = ext_seen_ff + 1'b1;
               if (nh_generic) begin
                  kind_in = KIND_GENERIC;
               end else if (cur_nh_in == NH_AH) begin
                  kind_in = KIND_AH;
               end else begin
                  kind_in = KIND_FRAG;
               end
               phase_in = PH_EXT_NEXT;
            end
         end else if ({1'b0, decl_len_in} >= ext_total_in) begin
            phase_in = PH_PAY_LIMITED;
         end else begin
            phase_in = PH_PAY_ALL;
         end
      end

      position_in = (position_ff != '1) ? position_ff + 1'b1 : position_ff;

      st = err_in;
      if (err_in == ST_OK &&
          (phase_in == PH_BASE || phase_in == PH_EXT_NEXT ||
           phase_in == PH_EXT_LEN || phase_in == PH_EXT_BODY)) begin
         st = ST_TRUNCATED;
      end

      step_result             = '0;
      step_result.data_out    = b;
      step_result.byte_class  = cls;
      step_result.byte_offset = OFFSET_BITS'(position_ff);
      if (step_item.is_last_byte) begin
         step_result.packet_done     = 1'b1;
         step_result.status          = st;
         step_result.upper_protocol  = cur_nh_in;
         step_result.hop_limit_out   = hop_limit_in;
         step_result.extension_count = ext_seen_in;
         step_result.payload_count   = pay_seen_in;
         step_result.trimmed_count   = trim_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_valid && step_item.is_last_byte)) begin
         phase_ff     <= PH_BASE;
         position_ff  <= '0;
         decl_len_ff  <= '0;
         cur_nh_ff    <= '0;
         pend_nh_ff   <= '0;
         hop_limit_ff <= '0;
         kind_ff      <= KIND_GENERIC;
         left_ff      <= '0;
         ext_seen_ff  <= '0;
         ext_total_ff <= '0;
         pay_seen_ff  <= '0;
         trim_seen_ff <= '0;
         err_ff       <= ST_OK;
      end else if (step_valid) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         decl_len_ff  <= decl_len_in;
         cur_nh_ff    <= cur_nh_in;
         pend_nh_ff   <= pend_nh_in;
         hop_limit_ff <= hop_limit_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         ext_seen_ff  <= ext_seen_in;
         ext_total_ff <= ext_total_in;
         pay_seen_ff  <= pay_seen_in;
         trim_seen_ff <= trim_seen_in;
         err_ff       <= err_in;
      end
   end

endmodule

>>> rtl/ipv6_extension_chain_parser.sv
// ----------------------------------------------------------------------------
// ipv6_extension_chain_parser
// Byte-stream IPv6 base header and extension header chain parser.
// ----------------------------------------------------------------------------
// The req_ channel carries one packet word per handshake: a byte and a flag
// that marks the last byte of the packet. Every accepted word produces exactly
// one word on the rsp_ channel: the byte itself, its class (base header,
// extension header, payload, trimmed trailer or discarded) and its offset.
// On the last byte the response also carries the packet summary: status,
// upper-layer protocol, hop limit, extension header count and the saturating
// payload and trimmed byte counts. Those summary fields are zero otherwise.
// The csr_ channel writes the extension header limit; it is always ready and
// should only be written while no packet is in flight.
// An accepted word is held in the input register and is parsed as it moves
// on into the response register, which drives rsp_valid and rsp_item.
// Throughput is one word per cycle while rsp_ready stays high; the single
// parse update between the input register and the response register sets
// that figure. Reset clears the valid flags of both registers and the parse
// state and restores the limit to 16. When the receiver holds rsp_ready low
// the response register holds, the input register fills, and then req_ready
// falls until the stall clears.
// ----------------------------------------------------------------------------
module ipv6_extension_chain_parser
   import ipv6ecp_pkg::*;
#(
   parameter int POSITION_BITS = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   logic                  in_valid_ff,  in_valid_in;
   req_type               in_item_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_item_ff;
   logic [LIMIT_BITS-1:0] max_ext_ff;
   logic                  advance;
   rsp_type               step_result;

   // The held word moves into the response register whenever that register
   // is empty or is being drained in this same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   ipv6ecp_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_item   (in_item_ff),
      .max_ext     (max_ext_ff),
      .step_result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ext_ff   <= MAX_EXT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_ext_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

endmodule
